>>> sv/ascii_art_cell_renderer_macros.svh
// ----------------------------------------------------------------------------
// ascii_art_cell_renderer_macros
// assertion helpers shared by the renderer rtl, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASCII_ART_CELL_RENDERER_MACROS_SVH
`define ASCII_ART_CELL_RENDERER_MACROS_SVH

// same-cycle implication
`define AACR_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define AACR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> sv/aacr_pkg.sv
// ----------------------------------------------------------------------------
// aacr_pkg
// shared widths, register indexes, luma constants and the glyph table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aacr_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_COLUMNS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_ROWS    = 2'd3;

  // register widths and reset values
  localparam int IMG_W_W = 10;
  localparam int IMG_H_W = 9;
  localparam int COLS_W  = 8;
  localparam int ROWS_W  = 7;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 10'd320;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 9'd240;
  localparam logic [COLS_W-1:0]  CELL_COLUMNS_RST = 8'd120;
  localparam logic [ROWS_W-1:0]  CELL_ROWS_RST    = 7'd40;

  // word field widths
  localparam int PX_W    = 9;
  localparam int PY_W    = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int COLOR_W = 8;
  localparam int RGB_W   = 3 * COLOR_W;
  localparam int CHAR_W  = 7;
  localparam int LEVEL_W = 4;

  // store geometry defaults
  localparam int DEFAULT_MAX_IMAGE_WIDTH  = 512;
  localparam int DEFAULT_MAX_IMAGE_HEIGHT = 256;

  // sample position divider: (2*idx+1)*size / (2*count)
  localparam int NUM_W_X = COL_W + 1 + IMG_W_W;
  localparam int NUM_W_Y = ROW_W + 1 + IMG_H_W;
  localparam int NUM_W   = (NUM_W_X > NUM_W_Y) ? NUM_W_X : NUM_W_Y;
  localparam int DEN_W_X = COLS_W + 1;
  localparam int DEN_W_Y = ROWS_W + 1;
  localparam int DEN_W   = (DEN_W_X > DEN_W_Y) ? DEN_W_X : DEN_W_Y;

  // luma and level
  localparam int LUMA_R_WT  = 299;
  localparam int LUMA_G_WT  = 587;
  localparam int LUMA_B_WT  = 114;
  localparam int LUMA_DIV   = 1000;
  localparam int LEVEL_DIV  = 18;
  localparam int LEVEL_MAX  = 14;
  localparam int LUMA_SUM_W =
    $clog2((LUMA_R_WT + LUMA_G_WT + LUMA_B_WT) * (2 ** COLOR_W - 1) + 1);

  typedef struct packed {
    logic render;
    logic write;
  } aacr_op_t;

  typedef struct packed {
    logic [PX_W-1:0]  px;
    logic [PY_W-1:0]  py;
    logic [RGB_W-1:0] rgb;
  } aacr_wr_t;

  // glyph ramp from darkest to lightest
  function automatic logic [CHAR_W-1:0] glyph(input logic [LEVEL_W-1:0] lvl);
    logic [CHAR_W-1:0] c;
    unique case (lvl)
      4'd0:    c = 7'h4D; // M
      4'd1:    c = 7'h4E; // N
      4'd2:    c = 7'h48; // H
      4'd3:    c = 7'h51; // Q
      4'd4:    c = 7'h24; // $
      4'd5:    c = 7'h4F; // O
      4'd6:    c = 7'h43; // C
      4'd7:    c = 7'h3F; // ?
      4'd8:    c = 7'h37; // 7
      4'd9:    c = 7'h3E; // >
      4'd10:   c = 7'h21; // !
      4'd11:   c = 7'h3A; // :
      4'd12:   c = 7'h2D; // -
      4'd13:   c = 7'h3B; // ;
      default: c = 7'h2E; // .
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/aacr_ram.sv
// ----------------------------------------------------------------------------
// aacr_ram
// single port synchronous ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aacr_ram #(
  parameter int WIDTH = aacr_pkg::RGB_W,
  parameter int DEPTH = aacr_pkg::DEFAULT_MAX_IMAGE_WIDTH * aacr_pkg::DEFAULT_MAX_IMAGE_HEIGHT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> sv/aacr_pos_pipe.sv
// ----------------------------------------------------------------------------
// aacr_pos_pipe
// pipelined restoring divider pair for the x and y sample positions,
// one quotient bit per stage, write words ride along unchanged
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aacr_pos_pipe #(
  parameter int NUM_W = aacr_pkg::NUM_W,
  parameter int DEN_W = aacr_pkg::DEN_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire aacr_pkg::aacr_op_t in_op,
  input  wire aacr_pkg::aacr_wr_t in_wr,
  input  wire logic [NUM_W-1:0]  num_x,
  input  wire logic [NUM_W-1:0]  num_y,
  input  wire logic [DEN_W-1:0]  den_x,
  input  wire logic [DEN_W-1:0]  den_y,
  output aacr_pkg::aacr_op_t      out_op,
  output aacr_pkg::aacr_wr_t      out_wr,
  output logic      [NUM_W-1:0]  quo_x,
  output logic      [NUM_W-1:0]  quo_y
);

  aacr_pkg::aacr_op_t op_q [NUM_W+1];
  aacr_pkg::aacr_wr_t wr_q [NUM_W+1];
  logic [NUM_W-1:0]   wx_q [NUM_W+1];
  logic [NUM_W-1:0]   wy_q [NUM_W+1];
  logic [DEN_W-1:0]   rx_q [NUM_W+1];
  logic [DEN_W-1:0]   ry_q [NUM_W+1];

  // shift one dividend bit into the remainder, one quotient bit into work
  function automatic logic [DEN_W+NUM_W-1:0] div_step(
    input logic [DEN_W-1:0] rem,
    input logic [NUM_W-1:0] work,
    input logic [DEN_W-1:0] den
  );
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    trial = {rem, work[NUM_W-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
    return ge ? {diff[DEN_W-1:0], work[NUM_W-2:0], 1'b1}
              : {trial[DEN_W-1:0], work[NUM_W-2:0], 1'b0};
  endfunction

  assign op_q[0] = in_op;
  assign wr_q[0] = in_wr;
  assign wx_q[0] = num_x;
  assign wy_q[0] = num_y;
  assign rx_q[0] = '0;
  assign ry_q[0] = '0;

  for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        op_q[k] <= '0;
      end else begin
        op_q[k] <= op_q[k-1];
      end
      wr_q[k] <= wr_q[k-1];
      {rx_q[k], wx_q[k]} <= div_step(rx_q[k-1], wx_q[k-1], den_x);
      {ry_q[k], wy_q[k]} <= div_step(ry_q[k-1], wy_q[k-1], den_y);
    end
  end

  assign out_op = op_q[NUM_W];
  assign out_wr = wr_q[NUM_W];
  assign quo_x  = wx_q[NUM_W];
  assign quo_y  = wy_q[NUM_W];

endmodule

`default_nettype wire

>>> sv/ascii_art_cell_renderer.sv
// ----------------------------------------------------------------------------
// ascii_art_cell_renderer
// rgb frame store with nearest-neighbor character cell rendering
// ----------------------------------------------------------------------------
// Takes one input word per cycle while in_ready is high and delivers one
// result word per cycle while results wait and out_ready is high. Pixel
// writes and cell renders share one pipeline in arrival order, so a render
// always sees every write accepted before it. A render passes through one
// entry register, an 18-stage restoring divider that makes one quotient bit
// of the sample positions per stage, clamp, address, the frame ram read and
// two luma stages. Results land in a 32-word queue; in_ready drops while 32
// renders are outstanding, so a stalled output side holds the input off
// before the pipeline and queue together are full. Frame ram contents are
// undefined until written and the block needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_art_cell_renderer_macros.svh"

module ascii_art_cell_renderer #(
  parameter int MAX_IMAGE_WIDTH  = aacr_pkg::DEFAULT_MAX_IMAGE_WIDTH,
  parameter int MAX_IMAGE_HEIGHT = aacr_pkg::DEFAULT_MAX_IMAGE_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,

  input  wire logic                             cfg_write,
  input  wire logic [aacr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [aacr_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             command,
  input  wire logic [aacr_pkg::PX_W-1:0]        pixel_x,
  input  wire logic [aacr_pkg::PY_W-1:0]        pixel_y,
  input  wire logic [aacr_pkg::COLOR_W-1:0]     red_in,
  input  wire logic [aacr_pkg::COLOR_W-1:0]     green_in,
  input  wire logic [aacr_pkg::COLOR_W-1:0]     blue_in,
  input  wire logic [aacr_pkg::COL_W-1:0]       cell_col,
  input  wire logic [aacr_pkg::ROW_W-1:0]       cell_row,

  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [aacr_pkg::CHAR_W-1:0]      char_code,
  output logic      [aacr_pkg::LEVEL_W-1:0]     level,
  output logic      [aacr_pkg::COLOR_W-1:0]     red_out,
  output logic      [aacr_pkg::COLOR_W-1:0]     green_out,
  output logic      [aacr_pkg::COLOR_W-1:0]     blue_out
);

  localparam int NUM_W      = aacr_pkg::NUM_W;
  localparam int DEN_W      = aacr_pkg::DEN_W;
  localparam int IMG_W_W    = aacr_pkg::IMG_W_W;
  localparam int IMG_H_W    = aacr_pkg::IMG_H_W;
  localparam int COLOR_W    = aacr_pkg::COLOR_W;
  localparam int RGB_W      = aacr_pkg::RGB_W;
  localparam int SUM_W      = aacr_pkg::LUMA_SUM_W;
  localparam int LEVEL_MAX  = aacr_pkg::LEVEL_MAX;
  localparam int XW         = $clog2(MAX_IMAGE_WIDTH);
  localparam int YW         = $clog2(MAX_IMAGE_HEIGHT);
  localparam int DEPTH      = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int AW         = $clog2(DEPTH);
  localparam int FIFO_DEPTH = 2 ** $clog2(NUM_W + 8);
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int LEVEL_STEP = aacr_pkg::LUMA_DIV * aacr_pkg::LEVEL_DIV;

  typedef struct packed {
    logic [aacr_pkg::CHAR_W-1:0]  char_code;
    logic [aacr_pkg::LEVEL_W-1:0] level;
    logic [RGB_W-1:0]             rgb;
  } res_t;

  // configuration registers
  logic [IMG_W_W-1:0]          image_width;
  logic [IMG_H_W-1:0]          image_height;
  logic [aacr_pkg::COLS_W-1:0] cell_columns;
  logic [aacr_pkg::ROWS_W-1:0] cell_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= aacr_pkg::IMAGE_WIDTH_RST;
      image_height <= aacr_pkg::IMAGE_HEIGHT_RST;
      cell_columns <= aacr_pkg::CELL_COLUMNS_RST;
      cell_rows    <= aacr_pkg::CELL_ROWS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        aacr_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        aacr_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        aacr_pkg::CFG_CELL_COLUMNS: cell_columns <= cfg_data[aacr_pkg::COLS_W-1:0];
        aacr_pkg::CFG_CELL_ROWS:    cell_rows    <= cfg_data[aacr_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [IMG_W_W-1:0]          w_eff;
  logic [IMG_H_W-1:0]          h_eff;
  logic [aacr_pkg::COLS_W-1:0] cols_eff;
  logic [aacr_pkg::ROWS_W-1:0] rows_eff;

  assign w_eff = (image_width == '0) ? IMG_W_W'(1) :
                 (32'(image_width) > MAX_IMAGE_WIDTH) ? IMG_W_W'(MAX_IMAGE_WIDTH) :
                 image_width;
  assign h_eff = (image_height == '0) ? IMG_H_W'(1) :
                 (32'(image_height) > MAX_IMAGE_HEIGHT) ? IMG_H_W'(MAX_IMAGE_HEIGHT) :
                 image_height;
  assign cols_eff = (cell_columns == '0) ? aacr_pkg::COLS_W'(1) : cell_columns;
  assign rows_eff = (cell_rows == '0) ? aacr_pkg::ROWS_W'(1) : cell_rows;

  // credit for outstanding renders
  logic             in_acc;
  logic             out_acc;
  logic             render_acc;
  logic [CNT_W-1:0] credit;

  assign in_ready   = (credit < CNT_W'(FIFO_DEPTH));
  assign in_acc     = in_valid && in_ready;
  assign render_acc = in_acc && command;
  assign out_acc    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CNT_W'(render_acc) - CNT_W'(out_acc);
    end
  end

  // entry stage: numerators
  aacr_pkg::aacr_op_t e_op;
  aacr_pkg::aacr_wr_t e_wr;
  logic [NUM_W-1:0]   e_num_x;
  logic [NUM_W-1:0]   e_num_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_op <= '0;
    end else begin
      e_op.render <= render_acc;
      e_op.write  <= in_acc && !command && (32'(pixel_x) < MAX_IMAGE_WIDTH) &&
                     (32'(pixel_y) < MAX_IMAGE_HEIGHT);
    end
    e_wr.px  <= pixel_x;
    e_wr.py  <= pixel_y;
    e_wr.rgb <= {red_in, green_in, blue_in};
    e_num_x  <= NUM_W'({cell_col, 1'b1}) * NUM_W'(w_eff);
    e_num_y  <= NUM_W'({cell_row, 1'b1}) * NUM_W'(h_eff);
  end

  // position dividers
  aacr_pkg::aacr_op_t p_op;
  aacr_pkg::aacr_wr_t p_wr;
  logic [NUM_W-1:0]   p_qx;
  logic [NUM_W-1:0]   p_qy;

  aacr_pos_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_pos_pipe (
    .clk    (clk),
    .rst    (rst),
    .in_op  (e_op),
    .in_wr  (e_wr),
    .num_x  (e_num_x),
    .num_y  (e_num_y),
    .den_x  (DEN_W'({cols_eff, 1'b0})),
    .den_y  (DEN_W'({rows_eff, 1'b0})),
    .out_op (p_op),
    .out_wr (p_wr),
    .quo_x  (p_qx),
    .quo_y  (p_qy)
  );

  // clamp stage
  logic [IMG_W_W-1:0] x_clamp;
  logic [IMG_H_W-1:0] y_clamp;

  assign x_clamp = (p_qx >= NUM_W'(w_eff)) ? (w_eff - IMG_W_W'(1)) : p_qx[IMG_W_W-1:0];
  assign y_clamp = (p_qy >= NUM_W'(h_eff)) ? (h_eff - IMG_H_W'(1)) : p_qy[IMG_H_W-1:0];

  aacr_pkg::aacr_op_t c_op;
  logic [RGB_W-1:0]   c_rgb;
  logic [XW-1:0]      c_x;
  logic [YW-1:0]      c_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_op <= '0;
    end else begin
      c_op <= p_op;
    end
    c_rgb <= p_wr.rgb;
    c_x   <= p_op.write ? XW'(p_wr.px) : XW'(x_clamp);
    c_y   <= p_op.write ? YW'(p_wr.py) : YW'(y_clamp);
  end

  // address stage
  aacr_pkg::aacr_op_t a_op;
  logic [AW-1:0]      a_addr;
  logic [RGB_W-1:0]   a_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_op <= '0;
    end else begin
      a_op <= c_op;
    end
    a_addr <= AW'(c_y) * AW'(MAX_IMAGE_WIDTH) + AW'(c_x);
    a_rgb  <= c_rgb;
  end

  // frame store
  logic [RGB_W-1:0] ram_q;
  logic             d_render;

  aacr_ram #(
    .WIDTH (RGB_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (a_op.write),
    .addr  (a_addr),
    .wdata (a_rgb),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d_render <= 1'b0;
    end else begin
      d_render <= a_op.render;
    end
  end

  // luma sum
  logic             l_render;
  logic [SUM_W-1:0] l_sum;
  logic [RGB_W-1:0] l_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_render <= 1'b0;
    end else begin
      l_render <= d_render;
    end
    l_sum <= SUM_W'(aacr_pkg::LUMA_R_WT) * SUM_W'(ram_q[RGB_W-1 -: COLOR_W]) +
             SUM_W'(aacr_pkg::LUMA_G_WT) * SUM_W'(ram_q[2*COLOR_W-1 -: COLOR_W]) +
             SUM_W'(aacr_pkg::LUMA_B_WT) * SUM_W'(ram_q[COLOR_W-1:0]);
    l_rgb <= ram_q;
  end

  // level: luma/1000/18 equals sum/18000, never above the top level
  logic [LEVEL_MAX-1:0]           lvl_ge;
  logic                           v_render;
  logic [aacr_pkg::LEVEL_W-1:0]   v_level;
  logic [RGB_W-1:0]               v_rgb;

  always_comb begin
    for (int k = 1; k <= LEVEL_MAX; k++) begin
      lvl_ge[k-1] = (l_sum >= SUM_W'(k * LEVEL_STEP));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_render <= 1'b0;
    end else begin
      v_render <= l_render;
    end
    v_level <= aacr_pkg::LEVEL_W'($countones(lvl_ge));
    v_rgb   <= l_rgb;
  end

  // result queue
  res_t             fifo_mem [FIFO_DEPTH];
  logic [PTR_W:0]   wr_ptr;
  logic [PTR_W:0]   rd_ptr;
  logic [PTR_W:0]   fifo_count;
  res_t             head;

  always_ff @(posedge clk) begin
    if (v_render) begin
      fifo_mem[wr_ptr[PTR_W-1:0]] <= '{char_code: aacr_pkg::glyph(v_level),
                                       level: v_level, rgb: v_rgb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (v_render) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  assign fifo_count = wr_ptr - rd_ptr;
  assign out_valid  = (wr_ptr != rd_ptr);
  assign head       = fifo_mem[rd_ptr[PTR_W-1:0]];
  assign char_code  = head.char_code;
  assign level      = head.level;
  assign red_out    = head.rgb[RGB_W-1 -: COLOR_W];
  assign green_out  = head.rgb[2*COLOR_W-1 -: COLOR_W];
  assign blue_out   = head.rgb[COLOR_W-1:0];

  // assertions
  `AACR_ASSERT_IMPL(a_push_room, v_render, (32'(fifo_count) < FIFO_DEPTH), "result queue overflow")
  `AACR_ASSERT_IMPL(a_word_has_credit, out_valid, (credit != '0), "result word without credit")
  `AACR_ASSERT_NEXT(a_credit_up, (render_acc && !out_acc), (credit == $past(credit) + 1'b1), "credit not taken")

endmodule

`default_nettype wire

>>> tb/sv/ascii_art_cell_renderer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_art_cell_renderer_checker
// Watches the configuration port and both word channels of the renderer.
// Keeps a shadow frame store and shadow geometry registers. For each render
// word it predicts the glyph, level and color that the block must return.
// Returned words are compared in order, field by field.
// ----------------------------------------------------------------------------
module ascii_art_cell_renderer_checker
  import aacr_pkg::*;
#(
  parameter int   MAX_W      = DEFAULT_MAX_IMAGE_WIDTH,
  parameter int   MAX_H      = DEFAULT_MAX_IMAGE_HEIGHT,
  parameter logic RENDER_CMD = 1'b1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   command,
  input  logic [PX_W-1:0]        pixel_x,
  input  logic [PY_W-1:0]        pixel_y,
  input  logic [COLOR_W-1:0]     red_in,
  input  logic [COLOR_W-1:0]     green_in,
  input  logic [COLOR_W-1:0]     blue_in,
  input  logic [COL_W-1:0]       cell_col,
  input  logic [ROW_W-1:0]       cell_row,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [CHAR_W-1:0]      char_code,
  input  logic [LEVEL_W-1:0]     level,
  input  logic [COLOR_W-1:0]     red_out,
  input  logic [COLOR_W-1:0]     green_out,
  input  logic [COLOR_W-1:0]     blue_out,
  output int                     fails,
  output int                     pending
);

  // darkest glyph first
  localparam logic [8*(LEVEL_MAX+1)-1:0] GLYPH_RAMP = "MNHQ$OC?7>!:-;.";
  localparam int NO_CAP = 1 << 30;

  typedef struct packed {
    logic [CHAR_W-1:0]  glyph;
    logic [LEVEL_W-1:0] lvl;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } cell_word_t;

  logic [RGB_W-1:0]   frame [MAX_W*MAX_H];
  cell_word_t         cells_due [$];
  logic [IMG_W_W-1:0] img_w     = IMAGE_WIDTH_RST;
  logic [IMG_H_W-1:0] img_h     = IMAGE_HEIGHT_RST;
  logic [COLS_W-1:0]  grid_cols = CELL_COLUMNS_RST;
  logic [ROWS_W-1:0]  grid_rows = CELL_ROWS_RST;
  int                 mismatches = 0;

  assign fails = mismatches;

  function automatic int fit(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int nearest(input int idx, input int size, input int count);
    int p;
    p = ((2 * idx + 1) * size) / (2 * count);
    if (p >= size) p = size - 1;
    return p;
  endfunction

  function automatic cell_word_t predict_cell(input int col, input int row);
    int         x;
    int         y;
    int         luma;
    int         lvl;
    cell_word_t w;
    x = nearest(col, fit(img_w, MAX_W), fit(grid_cols, NO_CAP));
    y = nearest(row, fit(img_h, MAX_H), fit(grid_rows, NO_CAP));
    {w.r, w.g, w.b} = frame[y * MAX_W + x];
    luma = (LUMA_R_WT * w.r + LUMA_G_WT * w.g + LUMA_B_WT * w.b) / LUMA_DIV;
    lvl = luma / LEVEL_DIV;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    w.lvl = lvl;
    w.glyph = GLYPH_RAMP[8 * (LEVEL_MAX - lvl) +: 8];
    return w;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    cell_word_t want;
    if (rst) begin
      img_w = IMAGE_WIDTH_RST;
      img_h = IMAGE_HEIGHT_RST;
      grid_cols = CELL_COLUMNS_RST;
      grid_rows = CELL_ROWS_RST;
      cells_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (cells_due.size() == 0) begin
          $error("result word with none expected");
          mismatches++;
        end else begin
          want = cells_due.pop_front();
          check_field("char_code", want.glyph, char_code);
          check_field("level", want.lvl, level);
          check_field("red_out", want.r, red_out);
          check_field("green_out", want.g, green_out);
          check_field("blue_out", want.b, blue_out);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  img_w = cfg_data[IMG_W_W-1:0];
          CFG_IMAGE_HEIGHT: img_h = cfg_data[IMG_H_W-1:0];
          CFG_CELL_COLUMNS: grid_cols = cfg_data[COLS_W-1:0];
          CFG_CELL_ROWS:    grid_rows = cfg_data[ROWS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (command == RENDER_CMD) begin
          cells_due.push_back(predict_cell(cell_col, cell_row));
        end else if (pixel_x < MAX_W && pixel_y < MAX_H) begin
          frame[pixel_y * MAX_W + pixel_x] = {red_in, green_in, blue_in};
        end
      end
    end
    pending <= cells_due.size();
  end

endmodule

>>> tb/sv/ascii_art_cell_renderer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_art_cell_renderer_tb
// Stimulus and verdict for the character cell renderer.
// A short directed run covers black, white, level boundaries and primaries,
// the last cell and cells beyond the grid. Random phases follow across the
// geometry extremes and random settings, with and without idling on either
// side. One phase holds the output off long enough to fill the block.
// Pixels that a render samples are always written first.
// ----------------------------------------------------------------------------
module ascii_art_cell_renderer_tb;
  import aacr_pkg::*;

  localparam int   MAX_W        = DEFAULT_MAX_IMAGE_WIDTH;
  localparam int   MAX_H        = DEFAULT_MAX_IMAGE_HEIGHT;
  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_RENDER   = 1'b1;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   QUIET_LIMIT  = 4000;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   PHASE_WORDS  = 135;
  localparam int   NO_CAP       = 1 << 30;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   command    = CMD_WRITE;
  logic [PX_W-1:0]        pixel_x    = '0;
  logic [PY_W-1:0]        pixel_y    = '0;
  logic [COLOR_W-1:0]     red_in     = '0;
  logic [COLOR_W-1:0]     green_in   = '0;
  logic [COLOR_W-1:0]     blue_in    = '0;
  logic [COL_W-1:0]       cell_col   = '0;
  logic [ROW_W-1:0]       cell_row   = '0;
  logic                   out_ready  = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic [CHAR_W-1:0]      char_code;
  logic [LEVEL_W-1:0]     level;
  logic [COLOR_W-1:0]     red_out;
  logic [COLOR_W-1:0]     green_out;
  logic [COLOR_W-1:0]     blue_out;
  int                     fails;
  int                     pending;

  logic [IMG_W_W-1:0] img_w     = IMAGE_WIDTH_RST;
  logic [IMG_H_W-1:0] img_h     = IMAGE_HEIGHT_RST;
  logic [COLS_W-1:0]  grid_cols = CELL_COLUMNS_RST;
  logic [ROWS_W-1:0]  grid_rows = CELL_ROWS_RST;
  bit                 painted [MAX_W*MAX_H];

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_start    = 1'b0;
  logic hold_taken    = 1'b0;
  int   hold_left     = 0;
  int   quiet         = 0;

  ascii_art_cell_renderer dut (.*);

  ascii_art_cell_renderer_checker #(.RENDER_CMD(CMD_RENDER)) cell_check (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // output side: random stalls, plus one long hold counted here
  always @(posedge clk) begin
    if (hold_start && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int fit(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int sample_at(input int idx, input int size, input int count);
    int p;
    p = ((2 * idx + 1) * size) / (2 * count);
    if (p >= size) p = size - 1;
    return p;
  endfunction

  task automatic put_word(input logic cmd, input logic [PX_W-1:0] px,
                          input logic [PY_W-1:0] py, input logic [RGB_W-1:0] rgb,
                          input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    in_valid <= 1'b1;
    command <= cmd;
    pixel_x <= px;
    pixel_y <= py;
    {red_in, green_in, blue_in} <= rgb;
    cell_col <= col;
    cell_row <= row;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_WRITE) painted[py * MAX_W + px] = 1'b1;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // write the sampled pixel first when asked to repaint or when it holds no color yet
  task automatic render_cell(input int col, input int row, input bit repaint,
                             input logic [RGB_W-1:0] rgb);
    int x;
    int y;
    x = sample_at(col, fit(img_w, MAX_W), fit(grid_cols, NO_CAP));
    y = sample_at(row, fit(img_h, MAX_H), fit(grid_rows, NO_CAP));
    if (repaint || !painted[y * MAX_W + x])
      put_word(CMD_WRITE, x, y, rgb, $urandom, $urandom);
    put_word(CMD_RENDER, $urandom, $urandom, $urandom, col, row);
  endtask

  task automatic run_random(input int words, input int write_pct);
    int col;
    int row;
    int lim_c;
    int lim_r;
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(99) < write_pct) begin
        put_word(CMD_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        lim_c = fit(grid_cols, NO_CAP) - 1;
        lim_r = fit(grid_rows, NO_CAP) - 1;
        if (lim_c > 127) lim_c = 127;
        if (lim_r > 63) lim_r = 63;
        col = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(lim_c);
        row = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(lim_r);
        render_cell(col, row, $urandom_range(3) == 0, $urandom);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int h, input int c, input int r);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_CELL_COLUMNS, c);
    write_reg(CFG_CELL_ROWS, r);
    cfg_write <= 1'b0;
    img_w = w;
    img_h = h;
    grid_cols = c;
    grid_rows = r;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset geometry
    set_idling(0, 0);
    render_cell(0, 0, 1'b1, 24'h000000);
    render_cell(119, 39, 1'b1, 24'hFFFFFF);
    render_cell(127, 63, 1'b1, 24'h5A3C96);
    render_cell(1, 0, 1'b1, {3{8'd17}});
    render_cell(2, 0, 1'b1, {3{8'd18}});
    render_cell(3, 0, 1'b1, {3{8'd251}});
    render_cell(4, 0, 1'b1, {3{8'd252}});
    render_cell(5, 0, 1'b1, 24'hFF0000);
    render_cell(6, 0, 1'b1, 24'h00FF00);
    render_cell(7, 0, 1'b1, 24'h0000FF);
    put_word(CMD_WRITE, 511, 255, 24'hFFFFFF, 127, 63);
    put_word(CMD_WRITE, 0, 0, 24'hFFFFFF, 0, 0);
    render_cell(0, 0, 1'b0, '0);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0:       set_geometry(512, 256, 128, 64);
        1:       set_geometry(0, 0, 0, 0);
        2:       set_geometry(1023, 511, 255, 127);
        3:       set_geometry(1, 1, 1, 1);
        default: set_geometry($urandom_range(1023), $urandom_range(1023),
                              $urandom_range(1023), $urandom_range(1023));
      endcase
      case (p % 4)
        0:       set_idling(0, 0);
        1:       set_idling(77, 0);
        2:       set_idling(0, 77);
        default: set_idling(25, 25);
      endcase
      run_random(PHASE_WORDS, 35);
    end

    // long output hold while renders keep coming
    settle();
    set_geometry(IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST, CELL_COLUMNS_RST, CELL_ROWS_RST);
    set_idling(0, 0);
    hold_start <= 1'b1;
    run_random(150, 0);

    settle();
    if (fails == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/aacr_pkg.sv
sv/aacr_ram.sv
sv/aacr_pos_pipe.sv
sv/ascii_art_cell_renderer.sv
tb/sv/ascii_art_cell_renderer_checker.sv
tb/sv/ascii_art_cell_renderer_tb.sv
